/* hw/rtl/mbtp_pkg.sv */
package mbtp_pkg;

	localparam logic [15:0] SERVER_PORT_RESET = 16'd502;
	localparam logic [7:0]  FC_MASK = 8'h7f;
	localparam logic [7:0]  EXC_BIT = 8'h80;
	localparam int unsigned GROUP_SIZE = 7;
	localparam int unsigned MAX_RES = 6;
	localparam int unsigned LAY_N = 76;
	localparam int unsigned PC_W = $clog2(LAY_N);
	localparam int unsigned RES_IDX_W = $clog2(MAX_RES);
	localparam int unsigned RES_CNT_W = $clog2(MAX_RES + 1);

	typedef enum logic [3:0] {
		A_END, A_REST, A_DAT, A_SETN, A_GTOP, A_GBOT, A_LDC,
		A_FLD, A_CNT, A_CNT2, A_G7, A_GBYT, A_GBC, A_GWRD
	} act_t;

	typedef enum logic [4:0] {
		K_TRANS, K_PROTO, K_LENGTH, K_UNIT, K_FUNC, K_EXC, K_REF, K_LREF, K_REFTYPE,
		K_RDREF, K_WRREF, K_WORDS, K_RDWORDS, K_WRWORDS, K_BITS, K_BYTES, K_LBYTES,
		K_ANDMASK, K_ORMASK, K_DATA, K_PAD, K_NOTMB, K_TRUNC
	} kind_t;

	typedef enum logic [1:0] {
		DIR_QUERY = 2'd0,
		DIR_RESP  = 2'd1,
		DIR_UNCL  = 2'd2
	} dir_t;

	typedef struct packed {
		act_t             act;
		kind_t            kind;
		logic [2:0]       len;
		logic             grp;
		logic [PC_W-1:0]  tgt;
	} lay_op_t;

	typedef struct packed {
		logic [55:0]     hs;
		logic [16:0]     fpos;
		logic [16:0]     flen;
		logic [6:0]      fc;
		logic            exc;
		dir_t            dir;
		logic [PC_W-1:0] pc;
		logic [31:0]     acc;
		logic [16:0]     br;
		logic [16:0]     gbr;
		logic [16:0]     cnt;
		logic [15:0]     fcnt;
		logic [7:0]      gcnt;
		logic            rej;
	} st_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] value;
		logic [15:0] frame;
		logic [7:0]  grp;
		dir_t        dir;
		logic        exc;
		logic        last;
	} res_t;

	localparam lay_op_t LAY [LAY_N] = '{
		'{A_END, K_TRANS, 3'd0, 1'b0, 7'd0},
		'{A_FLD, K_EXC, 3'd1, 1'b0, 7'd0}, '{A_END, K_TRANS, 3'd0, 1'b0, 7'd0},
		'{A_FLD, K_REF, 3'd2, 1'b0, 7'd0}, '{A_FLD, K_BITS, 3'd2, 1'b0, 7'd0},
		'{A_END, K_TRANS, 3'd0, 1'b0, 7'd0},
		'{A_FLD, K_REF, 3'd2, 1'b0, 7'd0}, '{A_FLD, K_WORDS, 3'd2, 1'b0, 7'd0},
		'{A_END, K_TRANS, 3'd0, 1'b0, 7'd0},
		'{A_CNT, K_BYTES, 3'd1, 1'b0, 7'd0}, '{A_DAT, K_DATA, 3'd0, 1'b0, 7'd0},
		'{A_END, K_TRANS, 3'd0, 1'b0, 7'd0},
		'{A_FLD, K_REF, 3'd2, 1'b0, 7'd0}, '{A_SETN, K_TRANS, 3'd1, 1'b0, 7'd0},
		'{A_DAT, K_DATA, 3'd0, 1'b0, 7'd0}, '{A_FLD, K_PAD, 3'd1, 1'b0, 7'd0},
		'{A_END, K_TRANS, 3'd0, 1'b0, 7'd0},
		'{A_FLD, K_REF, 3'd2, 1'b0, 7'd0}, '{A_SETN, K_TRANS, 3'd2, 1'b0, 7'd0},
		'{A_DAT, K_DATA, 3'd0, 1'b0, 7'd0}, '{A_END, K_TRANS, 3'd0, 1'b0, 7'd0},
		'{A_SETN, K_TRANS, 3'd1, 1'b0, 7'd0}, '{A_DAT, K_DATA, 3'd0, 1'b0, 7'd0},
		'{A_END, K_TRANS, 3'd0, 1'b0, 7'd0},
		'{A_FLD, K_REF, 3'd2, 1'b0, 7'd0}, '{A_FLD, K_BITS, 3'd2, 1'b0, 7'd0},
		'{A_CNT, K_BYTES, 3'd1, 1'b0, 7'd0}, '{A_DAT, K_DATA, 3'd0, 1'b0, 7'd0},
		'{A_END, K_TRANS, 3'd0, 1'b0, 7'd0},
		'{A_FLD, K_REF, 3'd2, 1'b0, 7'd0}, '{A_FLD, K_WORDS, 3'd2, 1'b0, 7'd0},
		'{A_CNT, K_BYTES, 3'd1, 1'b0, 7'd0}, '{A_DAT, K_DATA, 3'd0, 1'b0, 7'd0},
		'{A_END, K_TRANS, 3'd0, 1'b0, 7'd0},
		'{A_G7, K_BYTES, 3'd1, 1'b0, 7'd0}, '{A_GTOP, K_TRANS, 3'd0, 1'b0, 7'd40},
		'{A_FLD, K_REFTYPE, 3'd1, 1'b1, 7'd0}, '{A_FLD, K_LREF, 3'd4, 1'b1, 7'd0},
		'{A_FLD, K_WORDS, 3'd2, 1'b1, 7'd0}, '{A_GBOT, K_TRANS, 3'd0, 1'b0, 7'd35},
		'{A_END, K_TRANS, 3'd0, 1'b0, 7'd0},
		'{A_GBYT, K_BYTES, 3'd1, 1'b0, 7'd0}, '{A_GTOP, K_TRANS, 3'd0, 1'b0, 7'd48},
		'{A_GBC, K_BYTES, 3'd1, 1'b1, 7'd47}, '{A_FLD, K_REFTYPE, 3'd1, 1'b1, 7'd0},
		'{A_LDC, K_TRANS, 3'd0, 1'b1, 7'd0}, '{A_DAT, K_DATA, 3'd0, 1'b1, 7'd0},
		'{A_GBOT, K_TRANS, 3'd0, 1'b0, 7'd42}, '{A_END, K_TRANS, 3'd0, 1'b0, 7'd0},
		'{A_GBYT, K_BYTES, 3'd1, 1'b0, 7'd0}, '{A_GTOP, K_TRANS, 3'd0, 1'b0, 7'd56},
		'{A_FLD, K_REFTYPE, 3'd1, 1'b1, 7'd0}, '{A_FLD, K_LREF, 3'd4, 1'b1, 7'd0},
		'{A_GWRD, K_WORDS, 3'd2, 1'b1, 7'd0}, '{A_DAT, K_DATA, 3'd0, 1'b1, 7'd0},
		'{A_GBOT, K_TRANS, 3'd0, 1'b0, 7'd50}, '{A_END, K_TRANS, 3'd0, 1'b0, 7'd0},
		'{A_FLD, K_REF, 3'd2, 1'b0, 7'd0}, '{A_FLD, K_ANDMASK, 3'd2, 1'b0, 7'd0},
		'{A_FLD, K_ORMASK, 3'd2, 1'b0, 7'd0}, '{A_END, K_TRANS, 3'd0, 1'b0, 7'd0},
		'{A_FLD, K_RDREF, 3'd2, 1'b0, 7'd0}, '{A_FLD, K_RDWORDS, 3'd2, 1'b0, 7'd0},
		'{A_FLD, K_WRREF, 3'd2, 1'b0, 7'd0}, '{A_FLD, K_WRWORDS, 3'd2, 1'b0, 7'd0},
		'{A_CNT, K_BYTES, 3'd1, 1'b0, 7'd0}, '{A_DAT, K_DATA, 3'd0, 1'b0, 7'd0},
		'{A_END, K_TRANS, 3'd0, 1'b0, 7'd0},
		'{A_FLD, K_REF, 3'd2, 1'b0, 7'd0}, '{A_END, K_TRANS, 3'd0, 1'b0, 7'd0},
		'{A_CNT2, K_LBYTES, 3'd2, 1'b0, 7'd0}, '{A_FLD, K_WORDS, 3'd2, 1'b0, 7'd0},
		'{A_LDC, K_TRANS, 3'd0, 1'b0, 7'd0}, '{A_DAT, K_DATA, 3'd0, 1'b0, 7'd0},
		'{A_END, K_TRANS, 3'd0, 1'b0, 7'd0},
		'{A_REST, K_DATA, 3'd0, 1'b0, 7'd0}
	};

	function automatic st_t enter_f(st_t s, logic [PC_W-1:0] pc);
		logic [PC_W-1:0] p;
		p = (32'(pc) >= LAY_N) ? '0 : pc;
		s.pc = p;
		if (LAY[p].act >= A_FLD) begin
			s.br  = 17'(LAY[p].len);
			s.acc = '0;
		end
		return s;
	endfunction

	function automatic st_t start_frame_f(st_t s);
		s.fpos = '0;
		s.flen = '0;
		s.hs   = '0;
		s.fc   = '0;
		s.exc  = 1'b0;
		s.pc   = '0;
		s.acc  = '0;
		s.br   = '0;
		s.gbr  = '0;
		s.cnt  = '0;
		s.gcnt = '0;
		return s;
	endfunction

	function automatic logic known_fc(logic [6:0] fc);
		return (fc >= 7'd1 && fc <= 7'd24) || fc == 7'd40 || fc == 7'd43 || fc >= 7'd125;
	endfunction

	function automatic logic [PC_W-1:0] layout_start(logic [6:0] fc, logic exc, dir_t dir);
		logic q;
		logic r;
		logic [PC_W-1:0] p;
		q = (dir == DIR_QUERY);
		r = (dir == DIR_RESP);
		case (fc)
			7'd1, 7'd2: p = q ? 7'd3 : r ? 7'd9 : 7'd0;
			7'd3, 7'd4: p = q ? 7'd6 : r ? 7'd9 : 7'd0;
			7'd5:  p = (q || r) ? 7'd12 : 7'd0;
			7'd6:  p = (q || r) ? 7'd17 : 7'd0;
			7'd7:  p = r ? 7'd21 : 7'd0;
			7'd15: p = q ? 7'd24 : r ? 7'd3 : 7'd0;
			7'd16: p = q ? 7'd29 : r ? 7'd6 : 7'd0;
			7'd20: p = q ? 7'd34 : r ? 7'd41 : 7'd0;
			7'd21: p = (q || r) ? 7'd49 : 7'd0;
			7'd22: p = (q || r) ? 7'd57 : 7'd0;
			7'd23: p = q ? 7'd61 : r ? 7'd9 : 7'd0;
			7'd24: p = q ? 7'd68 : r ? 7'd70 : 7'd0;
			default: p = 7'd75;
		endcase
		return exc ? 7'd1 : p;
	endfunction

	// Rounds a byte down to a whole number of seven-byte groups.
	function automatic logic [16:0] group_bytes(logic [7:0] v);
		logic [18:0] prod;
		logic [7:0]  quo;
		prod = 19'(v) * 19'd293;
		quo  = 8'(prod >> 11);
		return 17'(quo) * 17'(GROUP_SIZE);
	endfunction

endpackage

/* hw/rtl/mbtp_step.sv */
module mbtp_step (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              take,
	input  logic [7:0]                        data_byte,
	input  logic [15:0]                       source_port,
	input  logic [15:0]                       destination_port,
	input  logic                              segment_first,
	input  logic                              segment_final,
	input  logic [15:0]                       server_port,
	output mbtp_pkg::res_t                    res [mbtp_pkg::MAX_RES],
	output logic [mbtp_pkg::RES_CNT_W-1:0]    res_n
);
	import mbtp_pkg::*;

	st_t st_q;
	st_t st_d;

	always_comb begin
		st_t             s;
		res_t            r [MAX_RES];
		logic [RES_CNT_W-1:0] n;
		logic [16:0]     pos;
		logic [15:0]     len;
		logic [15:0]     pid;
		lay_op_t         o;
		logic [7:0]      g;
		logic [31:0]     v;
		logic            done;
		kind_t           pk;
		logic [31:0]     pv;
		logic [7:0]      pg;
		logic            pput;

		s = st_q;
		n = '0;
		o = LAY[0];
		g = '0;
		v = '0;
		pos = '0;
		len = '0;
		pid = '0;
		done = 1'b0;
		pk = K_DATA;
		pv = '0;
		pg = '0;
		pput = 1'b0;
		for (int i = 0; i < MAX_RES; i++) begin
			r[i] = '0;
		end

		if (segment_first) begin
			if (source_port == server_port && destination_port != server_port) begin
				s.dir = DIR_RESP;
			end else if (source_port != server_port && destination_port == server_port) begin
				s.dir = DIR_QUERY;
			end else begin
				s.dir = DIR_UNCL;
			end
			s.rej  = 1'b0;
			s.fcnt = '0;
			s = start_frame_f(s);
		end

		if (!s.rej) begin
			pos = s.fpos;
			len = s.hs[23:8];
			pid = s.hs[39:24];
			if (pos < 17'd7) begin
				s.hs = {s.hs[47:0], data_byte};
			end else if (pos == 17'd7) begin
				s.fc  = data_byte[6:0] & FC_MASK[6:0];
				s.exc = |(data_byte & EXC_BIT);
				if (s.fcnt == '0 && (pid != '0 || len < 16'd2 || !known_fc(s.fc))) begin
					s.rej = 1'b1;
					r[n] = '{K_NOTMB, 32'd0, s.fcnt, 8'd0, s.dir, s.exc, 1'b0};
					n = n + 1'b1;
				end else begin
					r[0] = '{K_TRANS, 32'(s.hs[55:40]), s.fcnt, 8'd0, s.dir, s.exc, 1'b0};
					r[1] = '{K_PROTO, 32'(pid), s.fcnt, 8'd0, s.dir, s.exc, 1'b0};
					r[2] = '{K_LENGTH, 32'(len), s.fcnt, 8'd0, s.dir, s.exc, 1'b0};
					r[3] = '{K_UNIT, 32'(s.hs[7:0]), s.fcnt, 8'd0, s.dir, s.exc, 1'b0};
					r[4] = '{K_FUNC, 32'(s.fc), s.fcnt, 8'd0, s.dir, s.exc, 1'b0};
					n = RES_CNT_W'(5);
					s.flen = 17'd6 + ((len < 16'd2) ? 17'd2 : 17'(len));
					s = enter_f(s, layout_start(s.fc, s.exc, s.dir));
				end
			end else begin
				// Walk the steps that consume no byte, at most eight of them.
				for (int k = 0; k < 8; k++) begin
					if (!done) begin
						o = LAY[(32'(s.pc) < LAY_N) ? s.pc : '0];
						case (o.act)
							A_SETN: begin
								s.br = 17'(o.len);
								s = enter_f(s, s.pc + 1'b1);
							end
							A_LDC: begin
								s.br = s.cnt;
								s = enter_f(s, s.pc + 1'b1);
							end
							A_DAT: begin
								if (s.br != '0) begin
									done = 1'b1;
								end else begin
									s = enter_f(s, s.pc + 1'b1);
								end
							end
							A_GTOP: s = enter_f(s, (s.gbr != '0) ? s.pc + 1'b1 : o.tgt);
							A_GBOT: begin
								if (s.gcnt != 8'hff) begin
									s.gcnt = s.gcnt + 1'b1;
								end
								s = enter_f(s, o.tgt);
							end
							default: done = 1'b1;
						endcase
					end
				end
				if (32'(s.pc) >= LAY_N) begin
					s.pc = '0;
				end
				o = LAY[s.pc];
				g = o.grp ? s.gcnt : 8'd0;
				pput = 1'b0;
				pk = o.kind;
				pv = 32'(data_byte);
				pg = g;
				if (o.act == A_REST) begin
					pput = 1'b1;
					pg = 8'd0;
				end else if (o.act == A_DAT) begin
					if (s.br != '0) begin
						pput = 1'b1;
						s.br = s.br - 1'b1;
					end
				end else if (o.act >= A_FLD) begin
					s.acc = {s.acc[23:0], data_byte};
					if (s.br != '0) begin
						s.br = s.br - 1'b1;
					end
					if (s.br == '0) begin
						v = s.acc;
						pput = 1'b1;
						pv = v;
						case (o.act)
							A_CNT: begin
								s = enter_f(s, s.pc + 1'b1);
								s.br = v[16:0];
							end
							A_CNT2: begin
								s.cnt = (v >= 32'd2) ? 17'(v - 32'd2) : 17'd0;
								s = enter_f(s, s.pc + 1'b1);
							end
							A_G7: begin
								s.gbr  = group_bytes(v[7:0]);
								s.gcnt = '0;
								s = enter_f(s, s.pc + 1'b1);
							end
							A_GBYT: begin
								s.gbr  = v[16:0];
								s.gcnt = '0;
								s = enter_f(s, s.pc + 1'b1);
							end
							A_GBC: begin
								if (v == '0) begin
									s = enter_f(s, o.tgt);
								end else begin
									s.cnt = 17'(v - 32'd1);
									s = enter_f(s, s.pc + 1'b1);
								end
							end
							A_GWRD: begin
								s = enter_f(s, s.pc + 1'b1);
								s.br = {v[15:0], 1'b0};
							end
							default: s = enter_f(s, s.pc + 1'b1);
						endcase
					end
				end
				if (pput) begin
					r[n] = '{pk, pv, s.fcnt, pg, s.dir, s.exc, 1'b0};
					n = n + 1'b1;
				end
				if (o.grp && s.gbr != '0) begin
					s.gbr = s.gbr - 1'b1;
				end
			end

			if (!s.rej) begin
				if (pos >= 17'd7 && 18'(pos) + 18'd1 >= 18'(s.flen)) begin
					if (s.fcnt != 16'hffff) begin
						s.fcnt = s.fcnt + 1'b1;
					end
					s = start_frame_f(s);
				end else begin
					s.fpos = pos + 1'b1;
				end
				if (segment_final && s.fpos != '0 && n < RES_CNT_W'(MAX_RES)) begin
					r[n[RES_IDX_W-1:0]] = '{K_TRUNC, 32'(s.fpos), s.fcnt, 8'd0, s.dir, s.exc,
						1'b0};
					n = n + 1'b1;
				end
			end
		end

		if (n != '0) begin
			r[RES_IDX_W'(n - 1'b1)].last = 1'b1;
		end
		st_d = s;
		res  = r;
		res_n = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{hs: '0, fpos: '0, flen: '0, fc: '0, exc: 1'b0, dir: DIR_UNCL,
				pc: '0, acc: '0, br: '0, gbr: '0, cnt: '0, fcnt: '0, gcnt: '0, rej: 1'b0};
		end else if (take) begin
			st_q <= st_d;
		end
	end

endmodule

/* hw/rtl/modbus_tcp_frame_field_parser_top.sv */
// Results of a byte are registered; the first appears on the master side in the cycle after the byte is accepted.
// Throughput: one byte per cycle while each byte gives at most one result and the master
// side is ready; a byte that gives several results (a frame header gives five) holds the
// slave side until the result register has drained, one result per cycle while m_axis_tready.
// Reset: arst_n clears the parse state, empties the result register and sets server_port to 502.
module modbus_tcp_frame_field_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: the server port number.
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	// Slave side: one payload byte per transaction.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // data_byte, source_port, destination_port
	input  logic [0:0]  s_axis_tuser,  // segment_first
	input  logic        s_axis_tlast,  // segment_final
	// Master side: one parsed field per transaction.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // field_value, frame_number, group_number, direction
	output logic [5:0]  m_axis_tuser,  // field_kind, is_exception
	output logic        m_axis_tlast   // last result of the byte
);
	import mbtp_pkg::*;

	logic [15:0]          server_port_q;
	res_t                 res [MAX_RES];
	logic [RES_CNT_W-1:0] res_n;
	res_t                 buf_q [MAX_RES];
	logic [RES_CNT_W-1:0] cnt_q;
	logic                 take;
	logic                 pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_port_q <= SERVER_PORT_RESET;
		end else if (cfg_wr_en) begin
			server_port_q <= cfg_wr_data;
		end
	end

	// A new byte is taken once the result register is empty or gives up its last entry.
	assign pop  = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = (cnt_q == '0) || (cnt_q == RES_CNT_W'(1) && m_axis_tready);
	assign take = s_axis_tvalid && s_axis_tready;

	mbtp_step u_step (
		.clk              (clk),
		.arst_n           (arst_n),
		.take             (take),
		.data_byte        (s_axis_tdata[7:0]),
		.source_port      (s_axis_tdata[23:8]),
		.destination_port (s_axis_tdata[39:24]),
		.segment_first    (s_axis_tuser[0]),
		.segment_final    (s_axis_tlast),
		.server_port      (server_port_q),
		.res              (res),
		.res_n            (res_n)
	);

	// The result register is a short shift line read at its head.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (take) begin
			cnt_q <= res_n;
		end else if (pop) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			buf_q <= res;
		end else if (pop) begin
			for (int i = 0; i < MAX_RES - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
		end
	end

	assign m_axis_tvalid = (cnt_q != '0);
	assign m_axis_tdata  = {6'd0, buf_q[0].dir, buf_q[0].grp, buf_q[0].frame, buf_q[0].value};
	assign m_axis_tuser  = {buf_q[0].exc, buf_q[0].kind};
	assign m_axis_tlast  = buf_q[0].last;

endmodule

/* hw/rtl/mbtp_checker.sv */
module mbtp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic [5:0]  m_axis_tuser,
	input logic        m_axis_tlast
);
	import mbtp_pkg::*;

	// A waiting result holds its contents until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// Results of one byte follow each other without a gap.
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
		else $error("gap inside the results of one byte");

	// No new byte is taken while results of the current byte remain.
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("byte accepted with results pending");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser[4:0] <= 5'(K_TRUNC) && m_axis_tdata[57:56] != 2'd3)
		else $error("field kind or direction out of range");

endmodule

bind modbus_tcp_frame_field_parser_top mbtp_checker u_mbtp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

/* bench/tb_modbus_tcp_frame_field_parser_top.sv */
`timescale 1ns / 100ps

// Bench for the Modbus/TCP frame field parser: segments of payload bytes are pushed into
// the slave side, a software copy of the parser predicts every field token, and each
// token on the master side is checked against the oldest prediction.
module tb_modbus_tcp_frame_field_parser_top;
	import mbtp_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned RANDOM_BYTES = 24;
	localparam bit [16:0] CNT_MASK = 17'h1ffff;

	// One step of a field layout: what it does, the token kind it gives, its width,
	// whether it sits inside a group, and where it jumps.
	typedef struct {
		act_t        act;
		kind_t       kind;
		int unsigned len;
		bit          grp;
		int unsigned tgt;
	} layout_step_t;

	// One parsed field as it should appear on the master side.
	typedef struct packed {
		kind_t       kind;
		logic [31:0] value;
		logic [15:0] frame;
		logic [7:0]  grp;
		dir_t        dir;
		logic        exc;
		logic        last;
	} field_tok_t;

	// Field layouts, indexed by layout step. Entry points per function and direction are
	// chosen in layout_entry below.
	layout_step_t layout_plan [76] = '{
		'{A_END, K_TRANS, 0, 0, 0},
		'{A_FLD, K_EXC, 1, 0, 0}, '{A_END, K_TRANS, 0, 0, 0},
		'{A_FLD, K_REF, 2, 0, 0}, '{A_FLD, K_BITS, 2, 0, 0}, '{A_END, K_TRANS, 0, 0, 0},
		'{A_FLD, K_REF, 2, 0, 0}, '{A_FLD, K_WORDS, 2, 0, 0}, '{A_END, K_TRANS, 0, 0, 0},
		'{A_CNT, K_BYTES, 1, 0, 0}, '{A_DAT, K_DATA, 0, 0, 0}, '{A_END, K_TRANS, 0, 0, 0},
		'{A_FLD, K_REF, 2, 0, 0}, '{A_SETN, K_TRANS, 1, 0, 0}, '{A_DAT, K_DATA, 0, 0, 0},
		'{A_FLD, K_PAD, 1, 0, 0}, '{A_END, K_TRANS, 0, 0, 0},
		'{A_FLD, K_REF, 2, 0, 0}, '{A_SETN, K_TRANS, 2, 0, 0}, '{A_DAT, K_DATA, 0, 0, 0},
		'{A_END, K_TRANS, 0, 0, 0},
		'{A_SETN, K_TRANS, 1, 0, 0}, '{A_DAT, K_DATA, 0, 0, 0}, '{A_END, K_TRANS, 0, 0, 0},
		'{A_FLD, K_REF, 2, 0, 0}, '{A_FLD, K_BITS, 2, 0, 0}, '{A_CNT, K_BYTES, 1, 0, 0},
		'{A_DAT, K_DATA, 0, 0, 0}, '{A_END, K_TRANS, 0, 0, 0},
		'{A_FLD, K_REF, 2, 0, 0}, '{A_FLD, K_WORDS, 2, 0, 0}, '{A_CNT, K_BYTES, 1, 0, 0},
		'{A_DAT, K_DATA, 0, 0, 0}, '{A_END, K_TRANS, 0, 0, 0},
		// Read general reference query.
		'{A_G7, K_BYTES, 1, 0, 0}, '{A_GTOP, K_TRANS, 0, 0, 40},
		'{A_FLD, K_REFTYPE, 1, 1, 0}, '{A_FLD, K_LREF, 4, 1, 0},
		'{A_FLD, K_WORDS, 2, 1, 0}, '{A_GBOT, K_TRANS, 0, 0, 35}, '{A_END, K_TRANS, 0, 0, 0},
		// Read general reference response.
		'{A_GBYT, K_BYTES, 1, 0, 0}, '{A_GTOP, K_TRANS, 0, 0, 48},
		'{A_GBC, K_BYTES, 1, 1, 47}, '{A_FLD, K_REFTYPE, 1, 1, 0}, '{A_LDC, K_TRANS, 0, 1, 0},
		'{A_DAT, K_DATA, 0, 1, 0}, '{A_GBOT, K_TRANS, 0, 0, 42}, '{A_END, K_TRANS, 0, 0, 0},
		// Write general reference.
		'{A_GBYT, K_BYTES, 1, 0, 0}, '{A_GTOP, K_TRANS, 0, 0, 56},
		'{A_FLD, K_REFTYPE, 1, 1, 0}, '{A_FLD, K_LREF, 4, 1, 0}, '{A_GWRD, K_WORDS, 2, 1, 0},
		'{A_DAT, K_DATA, 0, 1, 0}, '{A_GBOT, K_TRANS, 0, 0, 50}, '{A_END, K_TRANS, 0, 0, 0},
		// Mask write.
		'{A_FLD, K_REF, 2, 0, 0}, '{A_FLD, K_ANDMASK, 2, 0, 0}, '{A_FLD, K_ORMASK, 2, 0, 0},
		'{A_END, K_TRANS, 0, 0, 0},
		// Read/write registers query.
		'{A_FLD, K_RDREF, 2, 0, 0}, '{A_FLD, K_RDWORDS, 2, 0, 0}, '{A_FLD, K_WRREF, 2, 0, 0},
		'{A_FLD, K_WRWORDS, 2, 0, 0}, '{A_CNT, K_BYTES, 1, 0, 0}, '{A_DAT, K_DATA, 0, 0, 0},
		'{A_END, K_TRANS, 0, 0, 0},
		// FIFO queue query, then response.
		'{A_FLD, K_REF, 2, 0, 0}, '{A_END, K_TRANS, 0, 0, 0},
		'{A_CNT2, K_LBYTES, 2, 0, 0}, '{A_FLD, K_WORDS, 2, 0, 0}, '{A_LDC, K_TRANS, 0, 0, 0},
		'{A_DAT, K_DATA, 0, 0, 0}, '{A_END, K_TRANS, 0, 0, 0},
		// Functions without a layout: every payload byte is data.
		'{A_REST, K_DATA, 0, 0, 0}
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic [0:0]  s_axis_tuser;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic [5:0]  m_axis_tuser;
	logic        m_axis_tlast;

	modbus_tcp_frame_field_parser_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	// Parser copy: server port and the per-segment, per-frame parse state.
	bit [15:0]   srv_port;
	bit [55:0]   hdr_shift;
	bit [16:0]   frm_pos;
	bit [16:0]   frm_len;
	bit [6:0]    fc_held;
	bit          exc_flag;
	dir_t        seg_dir;
	int unsigned step_idx;
	bit [31:0]   acc;
	bit [16:0]   bytes_left;
	bit [16:0]   grp_bytes_left;
	bit [16:0]   data_count;
	bit [15:0]   frm_count;
	bit [7:0]    grp_count;
	bit          seg_rejected;

	field_tok_t  expected_fields [$];
	field_tok_t  byte_fields [$];
	int unsigned mismatches;
	int unsigned cycle_count;

	// Sender burst shaping and the long receiver hold-off request.
	int unsigned burst_left;
	int unsigned hold_requests;
	bit [7:0]    frame_buf [$];

	// Clock, 20 ns period.
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Run-away guard: a correct run finishes far below this.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver: random phases of always-ready, mostly-ready and choppy acceptance,
	// plus a long hold-off whenever a test asks for one.
	int unsigned hold_seen;
	int unsigned hold_left;
	int unsigned phase_left;
	int unsigned phase_mode;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_seen <= 0;
			hold_left <= 0;
			phase_left <= 0;
			phase_mode <= 0;
		end else if (hold_seen != hold_requests) begin
			hold_seen <= hold_requests;
			hold_left <= 300;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			if (phase_left == 0) begin
				phase_left <= $urandom_range(40, 5);
				phase_mode <= $urandom_range(2, 0);
			end else begin
				phase_left <= phase_left - 1;
			end
			case (phase_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(9, 0) != 0);
				default: m_axis_tready <= 1'($urandom_range(1, 0));
			endcase
		end
	end

	task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] got_v);
		$display("[%0t] field mismatch on %s: expected %0h, got %0h", $realtime, what, exp_v,
			got_v);
		mismatches++;
	endtask

	// Checker: every accepted master transaction against the oldest prediction.
	always @(posedge clk) begin
		field_tok_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_fields.size() == 0) begin
				report("unexpected transaction", 32'h0, m_axis_tdata[31:0]);
			end else begin
				want = expected_fields.pop_front();
				if (m_axis_tuser[4:0] !== want.kind)
					report("field_kind", want.kind, m_axis_tuser[4:0]);
				if (m_axis_tdata[31:0] !== want.value)
					report("field_value", want.value, m_axis_tdata[31:0]);
				if (m_axis_tdata[47:32] !== want.frame)
					report("frame_number", want.frame, m_axis_tdata[47:32]);
				if (m_axis_tdata[55:48] !== want.grp)
					report("group_number", want.grp, m_axis_tdata[55:48]);
				if (m_axis_tdata[57:56] !== want.dir)
					report("direction", want.dir, m_axis_tdata[57:56]);
				if (m_axis_tuser[5] !== want.exc)
					report("is_exception", want.exc, m_axis_tuser[5]);
				if (m_axis_tlast !== want.last)
					report("tlast", want.last, m_axis_tlast);
			end
		end
	end

	// ---------------------------------------------------------------- parser copy

	task automatic emit_field(input kind_t kind, input bit [31:0] value, input bit [7:0] grp);
		field_tok_t f;
		if (byte_fields.size() >= MAX_RES)
			return;
		f.kind = kind;
		f.value = value;
		f.frame = frm_count;
		f.grp = grp;
		f.dir = seg_dir;
		f.exc = exc_flag;
		f.last = 1'b0;
		byte_fields.push_back(f);
	endtask

	task automatic goto_step(input int unsigned idx);
		if (idx >= 76)
			idx = 0;
		step_idx = idx;
		if (layout_plan[idx].act >= A_FLD) begin
			bytes_left = 17'(layout_plan[idx].len);
			acc = '0;
		end
	endtask

	task automatic clear_frame();
		frm_pos = '0;
		frm_len = '0;
		hdr_shift = '0;
		fc_held = '0;
		exc_flag = 1'b0;
		step_idx = 0;
		acc = '0;
		bytes_left = '0;
		grp_bytes_left = '0;
		data_count = '0;
		grp_count = '0;
	endtask

	function automatic bit function_known(input bit [6:0] fc);
		return (fc >= 1 && fc <= 24) || fc == 40 || fc == 43 || fc >= 125;
	endfunction

	// First layout step for a function, given the exception bit and the direction.
	// Request/response-only layouts have nothing to parse when the direction is unknown.
	function automatic int unsigned layout_entry(input bit [6:0] fc, input bit exc,
		input dir_t dir);
		bit q;
		bit r;
		q = (dir == DIR_QUERY);
		r = (dir == DIR_RESP);
		if (exc)
			return 1;
		case (fc)
			1, 2: return q ? 3 : r ? 9 : 0;
			3, 4: return q ? 6 : r ? 9 : 0;
			5: return (q || r) ? 12 : 0;
			6: return (q || r) ? 17 : 0;
			7: return r ? 21 : 0;
			15: return q ? 24 : r ? 3 : 0;
			16: return q ? 29 : r ? 6 : 0;
			20: return q ? 34 : r ? 41 : 0;
			21: return (q || r) ? 49 : 0;
			22: return (q || r) ? 57 : 0;
			23: return q ? 61 : r ? 9 : 0;
			24: return q ? 68 : r ? 70 : 0;
			default: return 75;
		endcase
	endfunction

	// Walks the steps that consume no byte: fixed counts, held counts, finished data runs
	// and group loop heads and tails.
	task automatic advance_idle_steps();
		layout_step_t op;
		for (int k = 0; k < 8; k++) begin
			op = layout_plan[step_idx < 76 ? step_idx : 0];
			case (op.act)
				A_SETN: begin
					bytes_left = 17'(op.len);
					goto_step(step_idx + 1);
				end
				A_LDC: begin
					bytes_left = data_count;
					goto_step(step_idx + 1);
				end
				A_DAT: begin
					if (bytes_left != 0)
						return;
					goto_step(step_idx + 1);
				end
				A_GTOP: goto_step(grp_bytes_left != 0 ? step_idx + 1 : op.tgt);
				A_GBOT: begin
					if (grp_count < 255)
						grp_count++;
					goto_step(op.tgt);
				end
				default: return;
			endcase
		end
	endtask

	task automatic parse_payload_byte(input bit [7:0] b);
		layout_step_t op;
		bit [7:0]  g;
		bit [31:0] v;
		advance_idle_steps();
		if (step_idx >= 76)
			step_idx = 0;
		op = layout_plan[step_idx];
		g = op.grp ? grp_count : 8'd0;
		if (op.act == A_REST) begin
			emit_field(K_DATA, 32'(b), 8'd0);
		end else if (op.act == A_DAT) begin
			if (bytes_left != 0) begin
				emit_field(K_DATA, 32'(b), g);
				bytes_left--;
			end
		end else if (op.act >= A_FLD) begin
			acc = (acc << 8) | 32'(b);
			if (bytes_left != 0)
				bytes_left--;
			if (bytes_left == 0) begin
				v = acc;
				emit_field(op.kind, v, g);
				case (op.act)
					A_CNT: begin
						goto_step(step_idx + 1);
						bytes_left = v[16:0];
					end
					A_CNT2: begin
						data_count = (v >= 2) ? 17'(v - 2) : 17'd0;
						goto_step(step_idx + 1);
					end
					A_G7: begin
						grp_bytes_left = 17'((v / 7) * 7);
						grp_count = 0;
						goto_step(step_idx + 1);
					end
					A_GBYT: begin
						grp_bytes_left = v[16:0];
						grp_count = 0;
						goto_step(step_idx + 1);
					end
					A_GBC: begin
						if (v == 0) begin
							goto_step(op.tgt);
						end else begin
							data_count = 17'(v - 1);
							goto_step(step_idx + 1);
						end
					end
					A_GWRD: begin
						goto_step(step_idx + 1);
						bytes_left = 17'(2 * v) & CNT_MASK;
					end
					default: goto_step(step_idx + 1);
				endcase
			end
		end
		if (op.grp && grp_bytes_left != 0)
			grp_bytes_left--;
	endtask

	// Predicts the tokens of one accepted byte and queues them.
	task automatic predict_fields(input bit [7:0] b, input bit [15:0] sp, input bit [15:0] dp,
		input bit first, input bit final_byte);
		bit [16:0] pos;
		bit [15:0] len_f;
		bit [15:0] pid;
		field_tok_t f;
		byte_fields.delete();
		if (first) begin
			if (sp == srv_port && dp != srv_port)
				seg_dir = DIR_RESP;
			else if (sp != srv_port && dp == srv_port)
				seg_dir = DIR_QUERY;
			else
				seg_dir = DIR_UNCL;
			seg_rejected = 1'b0;
			frm_count = '0;
			clear_frame();
		end
		if (!seg_rejected) begin
			pos = frm_pos;
			if (pos < 7) begin
				hdr_shift = {hdr_shift[47:0], b};
			end else if (pos == 7) begin
				len_f = hdr_shift[23:8];
				pid = hdr_shift[39:24];
				fc_held = b[6:0];
				exc_flag = b[7];
				// Only the first frame of a segment is screened.
				if (frm_count == 0 && (pid != 0 || len_f < 2 || !function_known(fc_held))) begin
					seg_rejected = 1'b1;
					emit_field(K_NOTMB, 32'd0, 8'd0);
				end else begin
					emit_field(K_TRANS, 32'(hdr_shift[55:40]), 8'd0);
					emit_field(K_PROTO, 32'(pid), 8'd0);
					emit_field(K_LENGTH, 32'(len_f), 8'd0);
					emit_field(K_UNIT, 32'(hdr_shift[7:0]), 8'd0);
					emit_field(K_FUNC, 32'(fc_held), 8'd0);
					frm_len = 17'd6 + (len_f < 2 ? 17'd2 : 17'(len_f));
					goto_step(layout_entry(fc_held, exc_flag, seg_dir));
				end
			end else begin
				parse_payload_byte(b);
			end
			if (!seg_rejected) begin
				if (pos >= 7 && 18'(pos) + 18'd1 >= 18'(frm_len)) begin
					if (frm_count != 16'hffff)
						frm_count++;
					clear_frame();
				end else begin
					frm_pos = pos + 17'd1;
				end
				if (final_byte && frm_pos != 0)
					emit_field(K_TRUNC, 32'(frm_pos), 8'd0);
			end
		end
		if (byte_fields.size() != 0)
			byte_fields[byte_fields.size() - 1].last = 1'b1;
		foreach (byte_fields[i]) begin
			f = byte_fields[i];
			expected_fields.push_back(f);
		end
	endtask

	// ---------------------------------------------------------------- stimulus

	// Offers one byte, with random gaps between bursts, waits for the transaction and
	// predicts its tokens.
	task automatic send_byte(input bit [7:0] b, input bit [15:0] sp, input bit [15:0] dp,
		input bit first, input bit final_byte);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(12, 1);
			gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {dp, sp, b};
		s_axis_tuser <= first;
		s_axis_tlast <= final_byte;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_fields(b, sp, dp, first, final_byte);
	endtask

	// Sends frame_buf as one segment; every byte carries the ports, the first one marks the segment start.
	task automatic send_segment(input bit [15:0] sp, input bit [15:0] dp);
		foreach (frame_buf[i])
			send_byte(frame_buf[i], sp, dp, i == 0, i == frame_buf.size() - 1);
		frame_buf.delete();
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_fields.size() != 0)
			@(posedge clk);
		// A byte that gives no token may still be in flight.
		repeat (4) @(posedge clk);
	endtask

	task automatic write_server_port(input bit [15:0] port);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= port;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		srv_port = port;
	endtask

	function automatic void push16(input int unsigned v);
		frame_buf.push_back(8'(v >> 8));
		frame_buf.push_back(8'(v));
	endfunction

	function automatic void push_random(input int unsigned n);
		repeat (n) frame_buf.push_back(8'($urandom_range(255, 0)));
	endfunction

	// Appends a well-formed frame for the given function byte and direction. A bad_len of
	// nonzero overrides the length field so frames overrun or end early.
	function automatic void build_frame(input bit [7:0] fc_byte, input bit query,
		input int unsigned bad_len, input int unsigned pid);
		bit [7:0] body [$];
		int unsigned base;
		int unsigned n;
		int unsigned w;
		int unsigned total;
		base = frame_buf.size();
		push16($urandom_range(65535, 0));
		push16(pid);
		push16(0);
		frame_buf.push_back(8'($urandom_range(255, 0)));
		frame_buf.push_back(fc_byte);
		if (fc_byte[7]) begin
			push_random(1);
		end else begin
			case (fc_byte[6:0])
				1, 2, 3, 4, 15, 16, 23: begin
					if (query && fc_byte[6:0] <= 4) begin
						push_random(4);
					end else if (!query && (fc_byte[6:0] == 15 || fc_byte[6:0] == 16)) begin
						push_random(4);
					end else begin
						if (query)
							push_random(fc_byte[6:0] == 23 ? 8 : 4);
						n = $urandom_range(6, 0);
						frame_buf.push_back(8'(n));
						push_random(n);
					end
				end
				5, 6: push_random(4);
				7: push_random(query ? 0 : 1);
				22: push_random(6);
				20: begin
					if (query) begin
						n = $urandom_range(2, 0);
						frame_buf.push_back(8'(7 * n));
						push_random(7 * n);
					end else begin
						total = 0;
						repeat ($urandom_range(3, 1)) begin
							n = $urandom_range(4, 0);
							body.push_back(8'(n));
							repeat (n) body.push_back(8'($urandom_range(255, 0)));
							total += n + 1;
						end
						frame_buf.push_back(8'(total));
						foreach (body[i]) frame_buf.push_back(body[i]);
					end
				end
				21: begin
					total = 0;
					repeat ($urandom_range(2, 1)) begin
						w = $urandom_range(2, 0);
						repeat (5) body.push_back(8'($urandom_range(255, 0)));
						body.push_back(8'(w >> 8));
						body.push_back(8'(w));
						repeat (2 * w) body.push_back(8'($urandom_range(255, 0)));
						total += 7 + 2 * w;
					end
					frame_buf.push_back(8'(total));
					foreach (body[i]) frame_buf.push_back(body[i]);
				end
				24: begin
					if (query) begin
						push_random(2);
					end else begin
						w = $urandom_range(3, 0);
						push16(2 + 2 * w);
						push16(w);
						push_random(2 * w);
					end
				end
				default: push_random($urandom_range(6, 0));
			endcase
		end
		total = (bad_len != 0) ? bad_len : frame_buf.size() - base - 6;
		frame_buf[base + 4] = 8'(total >> 8);
		frame_buf[base + 5] = 8'(total);
	endfunction

	function automatic bit [7:0] pick_function();
		int unsigned r;
		r = $urandom_range(29, 0);
		if (r < 24)
			return 8'(r + 1);
		case (r)
			24: return 8'd40;
			25: return 8'd43;
			26: return 8'd125;
			27: return 8'd126;
			default: return 8'd127;
		endcase
	endfunction

	// A random segment of one to three frames; mostly well-formed, sometimes with bad
	// lengths, exceptions, a bad protocol id or a cut-off final frame.
	task automatic send_random_segment(output int unsigned sent);
		bit [7:0] fc;
		bit query;
		bit [15:0] sp;
		bit [15:0] dp;
		int unsigned sel;
		int unsigned cut;
		sel = $urandom_range(3, 0);
		query = sel[0];
		sp = 16'($urandom_range(65535, 0));
		dp = 16'($urandom_range(65535, 0));
		if (sp == srv_port) sp = ~sp;
		if (dp == srv_port) dp = ~dp;
		case (sel)
			0: sp = srv_port;
			1: dp = srv_port;
			2: if ($urandom_range(1, 0)) begin sp = srv_port; dp = srv_port; end
			default: ;
		endcase
		repeat ($urandom_range(3, 1)) begin
			fc = pick_function();
			if ($urandom_range(7, 0) == 0)
				fc[7] = 1'b1;
			build_frame(fc, query, ($urandom_range(9, 0) == 0) ? $urandom_range(12, 1) : 0,
				($urandom_range(15, 0) == 0) ? $urandom_range(65535, 1) : 0);
		end
		if ($urandom_range(5, 0) == 0) begin
			cut = $urandom_range(frame_buf.size() - 1, 1);
			while (frame_buf.size() > cut)
				void'(frame_buf.pop_back());
		end
		sent = frame_buf.size();
		send_segment(sp, dp);
	endtask

	// ---------------------------------------------------------------- tests

	// A register read query toward the default server port, then an exception response.
	task automatic test_basic_frames();
		build_frame(8'd3, 1'b1, 0, 0);
		send_segment(16'd1024, SERVER_PORT_RESET);
		build_frame(8'h83, 1'b0, 0, 0);
		send_segment(SERVER_PORT_RESET, 16'hffff);
	endtask

	// First-frame screening: nonzero protocol id, too short a length and an unknown
	// function each reject the segment; a cut-off frame gives the truncation token.
	task automatic test_header_screening();
		build_frame(8'd4, 1'b1, 0, 16'hffff);
		send_segment(16'd0, SERVER_PORT_RESET);
		build_frame(8'd1, 1'b1, 1, 0);
		send_segment(16'd1, SERVER_PORT_RESET);
		build_frame(8'd25, 1'b1, 0, 0);
		send_segment(16'd2, SERVER_PORT_RESET);
		build_frame(8'd43, 1'b0, 0, 0);
		frame_buf.push_back(8'h55);
		send_segment(16'd3, 16'd4);
	endtask

	// Every register setting class: zero, all ones, random, then the default again.
	task automatic test_server_port_settings();
		int unsigned n;
		write_server_port(16'd0);
		build_frame(8'd6, 1'b1, 0, 0);
		send_segment(16'd1, 16'd0);
		write_server_port(16'hffff);
		build_frame(8'd6, 1'b0, 0, 0);
		send_segment(16'hffff, 16'd2);
		write_server_port(16'($urandom_range(65535, 0)));
		send_random_segment(n);
		write_server_port(SERVER_PORT_RESET);
	endtask

	// The receiver holds off for a long stretch while headers keep coming, so the result
	// register fills and the slave side stalls.
	task automatic test_backpressure();
		hold_requests++;
		build_frame(8'd21, 1'b1, 0, 0);
		build_frame(8'd24, 1'b1, 0, 0);
		send_segment(16'd7, SERVER_PORT_RESET);
	endtask

	// The sender pauses until every token is out, then starts again.
	task automatic test_drain_pause();
		build_frame(8'd5, 1'b1, 0, 0);
		send_segment(16'd8, SERVER_PORT_RESET);
		wait_drained();
		build_frame(8'd5, 1'b0, 0, 0);
		send_segment(SERVER_PORT_RESET, 16'd9);
	endtask

	task automatic test_random_segments();
		int unsigned total;
		int unsigned n;
		total = 0;
		while (total < RANDOM_BYTES) begin
			// Now and then a stray byte with segment_first low continues whatever came before.
			if ($urandom_range(9, 0) == 0) begin
				send_byte(8'($urandom_range(255, 0)), 16'($urandom_range(65535, 0)),
					16'($urandom_range(65535, 0)), 1'b0, 1'($urandom_range(1, 0)));
				total++;
			end
			send_random_segment(n);
			total += n;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		s_axis_tlast = 1'b0;
		mismatches = 0;
		cycle_count = 0;
		burst_left = 0;
		hold_requests = 0;
		srv_port = SERVER_PORT_RESET;
		seg_dir = DIR_UNCL;
		seg_rejected = 1'b0;
		frm_count = '0;
		clear_frame();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_frames();
		test_header_screening();
		test_server_port_settings();
		test_backpressure();
		test_drain_pause();
		test_random_segments();

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/mbtp_pkg.sv
hw/rtl/mbtp_step.sv
hw/rtl/modbus_tcp_frame_field_parser_top.sv
hw/rtl/mbtp_checker.sv
bench/tb_modbus_tcp_frame_field_parser_top.sv
